[hdl/crc_hb_pkg.sv]
`default_nettype none
package crc_hb_pkg;

  // Bucket store geometry
  localparam int NUM_BUCKETS     = 101;
  localparam int BUCKET_CAPACITY = 1024;
  localparam int BKT_W           = 7;
  localparam int CNT_W           = 11;

  // CRC-32, reflected form
  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

  // Reciprocal for hash mod NUM_BUCKETS: q_est = (hash * MOD_RECIP) >> MOD_SHIFT.
  // q_est is the true quotient or one below it.
  localparam int          MOD_SHIFT   = 31 + $clog2(NUM_BUCKETS);
  localparam logic [63:0] MOD_RECIP_W = (64'd1 << MOD_SHIFT) / NUM_BUCKETS;
  localparam logic [31:0] MOD_RECIP   = MOD_RECIP_W[31:0];
  localparam logic [31:0] NB_W        = NUM_BUCKETS;

  // Result queue depth, covers the pipeline latency
  localparam int RQ_DEPTH = 8;
  localparam int RQ_AW    = $clog2(RQ_DEPTH);
  localparam int RQ_CW    = $clog2(RQ_DEPTH + 1);

  typedef logic [31:0] crc_tab_t [256];

  // One-byte CRC step table, built at elaboration
  function automatic crc_tab_t build_step_lut();
    crc_tab_t    tab;
    logic [31:0] c;
    for (int i = 0; i < 256; i++) begin
      c = 32'(i);
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      tab[i] = c;
    end
    return tab;
  endfunction

  localparam crc_tab_t CRC_STEP_LUT = build_step_lut();

  // One entry of the result queue
  typedef struct packed {
    logic [31:0]      hash;
    logic [BKT_W-1:0] bucket;
    logic [CNT_W-1:0] count;
    logic             full;
  } result_t;

endpackage : crc_hb_pkg
`default_nettype wire

[hdl/crc32_hash_bucket_insert.sv]
// Channel  Signals                                   Moves
// in       in_valid/in_ready, byte_in, last          one byte of a word per request
// out      out_valid/out_ready, hash, bucket,        one insert result per word
//          entry_count, full_res
//
// One byte per cycle while in_ready is high; results pass the stages into a queue.
// The CRC register takes one table step per byte; the bucket counters sit in a
// one-port-read, one-port-write memory that is read, bumped and written back.
// Reset: CRC preset to all ones, per-bucket valid flags cleared.
// in_ready drops only when eight results are queued or in flight.
`default_nettype none
module crc32_hash_bucket_insert import crc_hb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       byte_in,
  input  wire logic             last,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [31:0]           hash,
  output logic [BKT_W-1:0]      bucket,
  output logic [CNT_W-1:0]      entry_count,
  output logic                  full_res
);

  // Handshakes and credit count
  logic             in_acc;
  logic             out_acc;
  logic [RQ_CW-1:0] pending;

  assign in_ready = (pending < RQ_CW'(RQ_DEPTH));
  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + RQ_CW'(in_acc && last) - RQ_CW'(out_acc);
    end
  end

  // CRC byte step
  logic [31:0] crc;
  logic [31:0] crc_next;
  logic [7:0]  crc_idx;

  assign crc_idx  = crc[7:0] ^ byte_in;
  assign crc_next = CRC_STEP_LUT[crc_idx] ^ (crc >> 8);

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= CRC_ONES;
    end else if (in_acc) begin
      crc <= last ? CRC_ONES : crc_next;
    end
  end

  // Stage 1: finished hash
  logic        v1;
  logic [31:0] hash1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else begin
      v1 <= in_acc && last;
    end
    hash1 <= crc_next ^ CRC_ONES;
  end

  // Stage 2: reciprocal product
  logic        v2;
  logic [31:0] hash2;
  logic [63:0] prod2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else begin
      v2 <= v1;
    end
    hash2 <= hash1;
    prod2 <= 64'(hash1) * 64'(MOD_RECIP);
  end

  // Stage 3: raw remainder, below twice the bucket count
  logic        v3;
  logic [31:0] hash3;
  logic [31:0] rem3;
  logic [31:0] quot2;

  assign quot2 = 32'(prod2 >> MOD_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else begin
      v3 <= v2;
    end
    hash3 <= hash2;
    rem3  <= hash2 - 32'(quot2 * NB_W);
  end

  // Stage 4: final correction, counter memory read
  logic [CNT_W-1:0] cnt_mem [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] cnt_vld;
  logic             v4;
  logic [31:0]      hash4;
  logic [BKT_W-1:0] bkt4;
  logic [BKT_W-1:0] bkt3;
  logic [CNT_W-1:0] rd4;
  logic             rdv4;

  assign bkt3 = (rem3 >= NB_W) ? BKT_W'(rem3 - NB_W) : BKT_W'(rem3);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else begin
      v4 <= v3;
    end
    hash4 <= hash3;
    bkt4  <= bkt3;
    rd4   <= cnt_mem[bkt3];
    rdv4  <= cnt_vld[bkt3];
  end

  // Stage 5: forward last write, saturate, write back
  logic             wr_v;
  logic [BKT_W-1:0] wr_addr;
  logic [CNT_W-1:0] wr_data;
  logic [CNT_W-1:0] cur5;
  logic             full5;
  logic [CNT_W-1:0] new5;

  always_comb begin
    if (wr_v && (wr_addr == bkt4)) begin
      cur5 = wr_data;
    end else begin
      cur5 = rdv4 ? rd4 : '0;
    end
    full5 = (32'(cur5) >= 32'(BUCKET_CAPACITY));
    new5  = full5 ? cur5 : cur5 + CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (v4 && !full5) begin
      cnt_mem[bkt4] <= new5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_vld <= '0;
      wr_v    <= 1'b0;
    end else begin
      if (v4) begin
        cnt_vld[bkt4] <= 1'b1;
      end
      wr_v <= v4;
    end
    wr_addr <= bkt4;
    wr_data <= new5;
  end

  // Result queue
  result_t          rq [RQ_DEPTH];
  logic [RQ_AW-1:0] rq_wp;
  logic [RQ_AW-1:0] rq_rp;
  logic [RQ_CW-1:0] rq_cnt;
  result_t          rq_head;

  always_ff @(posedge clk) begin
    if (v4) begin
      rq[rq_wp] <= '{hash: hash4, bucket: bkt4, count: new5, full: full5};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wp  <= '0;
      rq_rp  <= '0;
      rq_cnt <= '0;
    end else begin
      if (v4) begin
        rq_wp <= (rq_wp == RQ_AW'(RQ_DEPTH - 1)) ? '0 : rq_wp + RQ_AW'(1);
      end
      if (out_acc) begin
        rq_rp <= (rq_rp == RQ_AW'(RQ_DEPTH - 1)) ? '0 : rq_rp + RQ_AW'(1);
      end
      rq_cnt <= rq_cnt + RQ_CW'(v4) - RQ_CW'(out_acc);
    end
  end

  assign rq_head     = rq[rq_rp];
  assign out_valid   = (rq_cnt != '0);
  assign hash        = rq_head.hash;
  assign bucket      = rq_head.bucket;
  assign entry_count = rq_head.count;
  assign full_res    = rq_head.full;

  // Checks
  a_credit_bound: assert property (@(posedge clk) disable iff (rst)
    pending <= RQ_CW'(RQ_DEPTH))
    else $error("result credit count over queue depth");

  a_queue_in_credit: assert property (@(posedge clk) disable iff (rst)
    rq_cnt <= pending)
    else $error("queued results exceed outstanding requests");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (rq_cnt < RQ_CW'(RQ_DEPTH)) || out_acc)
    else $error("result pushed into a full queue");

  a_bucket_range: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (32'(bkt4) < NB_W))
    else $error("bucket index out of range");

  a_full_at_cap: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (32'(new5) <= 32'(BUCKET_CAPACITY)))
    else $error("bucket count above capacity");

  a_hash_latency: assert property (@(posedge clk) disable iff (rst)
    (in_acc && last) |-> ##4 v4)
    else $error("final byte did not reach the counter stage");

endmodule : crc32_hash_bucket_insert
`default_nettype wire
